### rtl/vpm_pkg.sv
// Package: payload types, widths and constants of the vehicle performance meter.
package vpm_pkg;

  localparam int unsigned CfgW = 19;
  localparam int unsigned SpdW = 19;
  localparam int unsigned AccW = 24;
  localparam int unsigned TimW = 26;
  localparam int unsigned RadW = 28;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned DivQW = 40;

  localparam logic [CfgW-1:0] MinCornerRst = 19'd16000;
  localparam logic [CfgW-1:0] LaunchTgtRst = 19'd44444;
  localparam logic [CfgW-1:0] ArmLowRst = 19'd160;
  localparam logic [CfgW-1:0] ArmHighRst = 19'd3200;
  localparam logic [CfgW-1:0] AbortRst = 19'd80;

  localparam logic [19:0] MinDtUs = 20'd100;
  localparam logic [19:0] MinYawQ16 = 20'd6;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_CORNER = 3'd0,
    REG_LAUNCH_TGT = 3'd1,
    REG_ARM_LOW    = 3'd2,
    REG_ARM_HIGH   = 3'd3,
    REG_ABORT      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [19:0] forward_speed;
    logic [19:0]        yaw_rate;
    logic [19:0]        delta_time;
  } vpm_in_t;

  typedef struct packed {
    logic            measuring;
    logic [SpdW-1:0] top_speed;
    logic [AccW-1:0] peak_forward_accel;
    logic [AccW-1:0] peak_braking_decel;
    logic [TimW-1:0] launch_time;
    logic            launch_timing;
    logic [AccW-1:0] peak_lateral_accel;
    logic [SpdW-1:0] speed_at_peak_lateral;
    logic [RadW-1:0] radius_at_peak_lateral;
    logic [RadW-1:0] tightest_radius;
  } vpm_out_t;

  typedef struct packed {
    logic [CfgW-1:0] min_corner;
    logic [CfgW-1:0] launch_tgt;
    logic [CfgW-1:0] arm_low;
    logic [CfgW-1:0] arm_high;
    logic [CfgW-1:0] abort_spd;
  } vpm_cfg_t;

endpackage

### rtl/vpm_serial_mul.sv
// Shift-add multiplier: one multiplier bit per cycle.
module vpm_serial_mul #(
  parameter int unsigned AW = 21,
  parameter int unsigned BW = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);
  localparam int unsigned CntW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_r, acc_nxt;
  logic [AW+BW-1:0] mcand_r, mcand_nxt;
  logic [BW-1:0]    mplier_r, mplier_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0;
      mcand_nxt = {{BW{1'b0}}, a};
      mplier_nxt = b;
      cnt_nxt = CntW'(BW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
      mcand_nxt = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

### rtl/vpm_serial_div.sv
// Restoring divider: one quotient bit per cycle.
module vpm_serial_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int unsigned CntW = $clog2(NW + 1);

  logic [DW:0]     rem_r, rem_nxt;
  logic [NW-1:0]   q_r, q_nxt;
  logic [DW-1:0]   den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DW:0]     trial;
  logic [DW+1:0]   diff;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt = q_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[DW-1:0], q_r[NW-1]};
    diff = {1'b0, trial} - {2'b00, den_r};
    if (start) begin
      rem_nxt = '0;
      q_nxt = num;
      den_nxt = den;
      cnt_nxt = CntW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in next numerator bit, subtract when it fits
      if (!diff[DW+1]) begin
        rem_nxt = diff[DW:0];
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo = q_r;
endmodule

### rtl/vehicle_performance_meter.sv
// Top level: vehicle performance meter with serial multiply and divide units.
//
//  channel | ports                      | direction | payload
//  in      | in_valid, in_ready, in_data | into block | vpm_in_t
//  out     | out_valid, out_ready, out_data | out of block | vpm_out_t
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | into block | 19-bit register
//
// A tick item with a previous speed runs through the prepare state, a 21x20 shift-add
// multiply (|dv| * 1e6), a 40-bit restoring divide by delta_time, the update state, a
// 19x20 multiply for lateral, a 40-bit divide by yaw for radius and the emit state; no
// new item is taken until the sequencer is back in idle. The first tick after start
// skips the acceleration pair, and a tick that skips cornering emits right after the
// update. Start, stop, short, inactive and ignored items go from the prepare state
// straight to the emit state. Reset is synchronous, active low.
// The next item is taken while a result waits in the output register; a stalled
// output holds the sequencer only when a new result must be written.
module vehicle_performance_meter (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  vpm_pkg::vpm_in_t        in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output vpm_pkg::vpm_out_t       out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [vpm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [vpm_pkg::CfgW-1:0]    cfg_data
);
  import vpm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL_A, S_DIV_A, S_UPD_A, S_MUL_L, S_DIV_R, S_UPD_C, S_EMIT
  } state_t;

  state_t   state_r;
  vpm_cfg_t cfg_r;
  vpm_in_t  item_r;

  logic                active_r, have_last_r, timing_r;
  logic [SpdW-1:0]     max_speed_r, spd_at_lat_r, speed_r;
  logic signed [19:0]  last_speed_r;
  logic [AccW-1:0]     max_fwd_r, max_brk_r, max_lat_r, lat_r;
  logic [TimW-1:0]     elapsed_r, launch_res_r;
  logic [RadW-1:0]     rad_at_lat_r, min_rad_r;
  logic                dv_pos_r;
  logic                out_valid_r;
  vpm_out_t            out_r;

  // shared multiplier and divider
  logic             mul_start, div_start, mul_done, div_done;
  logic [20:0]      mul_a;
  logic [19:0]      mul_b;
  logic [40:0]      mul_p;
  logic [DivQW-1:0] div_num, div_q;
  logic [19:0]      div_den;

  vpm_serial_mul #(.AW(21), .BW(20)) u_mul (
    .clk, .rst_n, .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  vpm_serial_div #(.NW(DivQW), .DW(20)) u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  logic signed [20:0] fs_ext, dv;
  logic [20:0]        fs_abs, dv_mag;
  logic [SpdW-1:0]    speed_sat;
  logic [AccW-1:0]    acc_sat, lat_sat;
  logic [RadW-1:0]    rad_sat;
  logic [TimW:0]      el_sum;
  logic [TimW-1:0]    el_sat;
  logic               corner_ok, tick_go, emit;

  always_comb begin
    fs_ext = 21'(item_r.forward_speed);
    dv = fs_ext - 21'(last_speed_r);
    dv_mag = dv[20] ? 21'(-dv) : 21'(dv);
    fs_abs = fs_ext[20] ? 21'(-fs_ext) : fs_ext;
    speed_sat = (fs_abs > 21'(SpdW'('1))) ? '1 : fs_abs[SpdW-1:0];
    acc_sat = (div_q > DivQW'(AccW'('1))) ? '1 : div_q[AccW-1:0];
    lat_sat = (mul_p[40:16] > 25'(AccW'('1))) ? '1 : mul_p[39:16];
    rad_sat = (div_q > DivQW'(RadW'('1))) ? '1 : div_q[RadW-1:0];
    el_sum = {1'b0, elapsed_r} + (TimW+1)'(item_r.delta_time);
    el_sat = el_sum[TimW] ? '1 : el_sum[TimW-1:0];
    corner_ok = (speed_r >= cfg_r.min_corner) && (item_r.yaw_rate > MinYawQ16);
    tick_go = (item_r.func == FUNC_TICK) && active_r && (item_r.delta_time > MinDtUs);
    emit = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  end

  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a = dv_mag;
    mul_b = 20'd1000000;
    div_num = DivQW'(mul_p);
    div_den = item_r.delta_time;
    case (state_r)
      S_PREP: begin
        mul_start = tick_go && have_last_r;
      end
      S_MUL_A: div_start = mul_done;
      S_UPD_A: begin
        mul_start = corner_ok;
        mul_a = 21'(speed_r);
        mul_b = item_r.yaw_rate;
      end
      S_MUL_L: begin
        div_start = mul_done;
        div_num = DivQW'({speed_r, 16'd0});
        div_den = item_r.yaw_rate;
      end
      default: ;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cfg_r <= '{MinCornerRst, LaunchTgtRst, ArmLowRst, ArmHighRst, AbortRst};
      active_r <= 1'b0;
      have_last_r <= 1'b0;
      timing_r <= 1'b0;
      max_speed_r <= '0;
      last_speed_r <= '0;
      max_fwd_r <= '0;
      max_brk_r <= '0;
      elapsed_r <= '0;
      launch_res_r <= '0;
      max_lat_r <= '0;
      spd_at_lat_r <= '0;
      rad_at_lat_r <= '0;
      min_rad_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MIN_CORNER: cfg_r.min_corner <= cfg_data;
          REG_LAUNCH_TGT: cfg_r.launch_tgt <= cfg_data;
          REG_ARM_LOW:    cfg_r.arm_low <= cfg_data;
          REG_ARM_HIGH:   cfg_r.arm_high <= cfg_data;
          REG_ABORT:      cfg_r.abort_spd <= cfg_data;
          default: ;
        endcase
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_data;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          state_r <= !tick_go ? S_EMIT : (have_last_r ? S_MUL_A : S_UPD_A);
          case (func_t'(item_r.func))
            FUNC_START: begin
              have_last_r <= 1'b0;
              timing_r <= 1'b0;
              max_speed_r <= '0;
              last_speed_r <= '0;
              max_fwd_r <= '0;
              max_brk_r <= '0;
              elapsed_r <= '0;
              launch_res_r <= '0;
              max_lat_r <= '0;
              spd_at_lat_r <= '0;
              rad_at_lat_r <= '0;
              min_rad_r <= '0;
              active_r <= 1'b1;
            end
            FUNC_STOP: active_r <= 1'b0;
            FUNC_TICK: begin
              if (tick_go) begin
                speed_r <= speed_sat;
                if (speed_sat > max_speed_r) max_speed_r <= speed_sat;
                dv_pos_r <= !dv[20] && (dv != '0);
                last_speed_r <= item_r.forward_speed;
                have_last_r <= 1'b1;
                // launch timer
                if (!timing_r && launch_res_r == '0 &&
                    fs_ext > $signed({2'b00, cfg_r.arm_low}) &&
                    fs_ext < $signed({2'b00, cfg_r.arm_high})) begin
                  timing_r <= 1'b1;
                  elapsed_r <= '0;
                end else if (timing_r) begin
                  elapsed_r <= el_sat;
                  if (fs_ext >= $signed({2'b00, cfg_r.launch_tgt})) begin
                    launch_res_r <= el_sat;
                    timing_r <= 1'b0;
                  end else if (fs_ext < $signed({2'b00, cfg_r.abort_spd})) begin
                    timing_r <= 1'b0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        S_MUL_A: if (mul_done) state_r <= S_DIV_A;
        S_DIV_A: begin
          if (div_done) begin
            if (dv_pos_r) begin
              if (acc_sat > max_fwd_r) max_fwd_r <= acc_sat;
            end else if ($signed(item_r.forward_speed) >
                         $signed({1'b0, cfg_r.min_corner})) begin
              if (acc_sat > max_brk_r) max_brk_r <= acc_sat;
            end
            state_r <= S_UPD_A;
          end
        end
        S_UPD_A: state_r <= corner_ok ? S_MUL_L : S_EMIT;
        S_MUL_L: begin
          if (mul_done) begin
            lat_r <= lat_sat;
            state_r <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_done) begin
            if (lat_r > max_lat_r) begin
              max_lat_r <= lat_r;
              spd_at_lat_r <= speed_r;
              rad_at_lat_r <= rad_sat;
            end
            if (min_rad_r == '0 || rad_sat < min_rad_r) min_rad_r <= rad_sat;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the output register is free
          if (emit) begin
            out_r <= '{active_r, max_speed_r, max_fwd_r, max_brk_r, launch_res_r,
                       timing_r, max_lat_r, spd_at_lat_r, rad_at_lat_r, min_rad_r};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/vehicle_performance_meter_tb.sv
// Testbench for the vehicle performance meter: directed table, random drives, own predictor.
module vehicle_performance_meter_tb;
  import vpm_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd6;
  localparam longint SpeedMax = 524287;
  localparam longint AccMax = 16777215;
  localparam longint TimeMax = 67108863;
  localparam longint RadMax = 268435455;
  localparam int SettleCycles = 200;

  typedef struct {
    func_t f;
    int    fs;
    int    yaw;
    int    dt;
    bit    typed;
    bit    meas;
  } table_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  vpm_in_t in_data;
  logic out_valid;
  logic out_ready;
  vpm_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  vehicle_performance_meter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // meter registers as the testbench sees them
  logic [CfgW-1:0] corner_floor, launch_goal, arm_lo, arm_hi, abort_floor;
  // meter figures
  bit m_active, m_have_last, m_timing;
  logic [SpdW-1:0] m_top_speed, m_lat_speed;
  logic signed [19:0] m_last_speed;
  logic [AccW-1:0] m_fwd_acc, m_brake_acc, m_lat_acc;
  logic [TimW-1:0] m_launch_run, m_launch_rec;
  logic [RadW-1:0] m_lat_radius, m_min_radius;

  vpm_out_t figures_due[$];
  int mismatches;
  int idle_mode;
  bit typed_next;
  vpm_out_t typed_val;
  table_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  function automatic void clear_figures();
    m_active = 0; m_have_last = 0; m_timing = 0;
    m_top_speed = '0; m_last_speed = '0; m_fwd_acc = '0; m_brake_acc = '0;
    m_launch_run = '0; m_launch_rec = '0; m_lat_acc = '0; m_lat_speed = '0;
    m_lat_radius = '0; m_min_radius = '0;
  endfunction

  function automatic void apply_tick(vpm_in_t d);
    longint fs, yaw, dt, speed, dv, mag, acc, run, lat, rad;
    fs = d.forward_speed;
    yaw = d.yaw_rate;
    dt = d.delta_time;
    if (!m_active || dt <= 100) return;
    speed = (fs < 0) ? -fs : fs;
    if (speed > SpeedMax) speed = SpeedMax;
    if (speed > m_top_speed) m_top_speed = SpdW'(speed);
    if (m_have_last) begin
      dv = fs - longint'(m_last_speed);
      mag = (dv < 0) ? -dv : dv;
      acc = mag * 1000000 / dt;
      if (acc > AccMax) acc = AccMax;
      if (dv > 0) begin
        if (acc > m_fwd_acc) m_fwd_acc = AccW'(acc);
      end else if (fs > longint'(corner_floor)) begin
        if (acc > m_brake_acc) m_brake_acc = AccW'(acc);
      end
    end
    m_last_speed = d.forward_speed;
    m_have_last = 1;
    if (!m_timing && m_launch_rec == 0 && fs > longint'(arm_lo) && fs < longint'(arm_hi)) begin
      m_timing = 1;
      m_launch_run = '0;
    end else if (m_timing) begin
      run = longint'(m_launch_run) + dt;
      m_launch_run = (run > TimeMax) ? TimW'(TimeMax) : TimW'(run);
      if (fs >= longint'(launch_goal)) begin
        m_launch_rec = m_launch_run;
        m_timing = 0;
      end else if (fs < longint'(abort_floor)) begin
        m_timing = 0;
      end
    end
    if (speed < longint'(corner_floor) || yaw <= 6) return;
    lat = (speed * yaw) >> 16;
    rad = (speed << 16) / yaw;
    if (lat > AccMax) lat = AccMax;
    if (rad > RadMax) rad = RadMax;
    if (lat > m_lat_acc) begin
      m_lat_acc = AccW'(lat);
      m_lat_speed = SpdW'(speed);
      m_lat_radius = RadW'(rad);
    end
    if (m_min_radius == 0 || rad < m_min_radius) m_min_radius = RadW'(rad);
  endfunction

  function automatic vpm_out_t meter_figures(vpm_in_t d);
    vpm_out_t o;
    case (func_t'(d.func))
      FUNC_TICK: apply_tick(d);
      FUNC_START: begin
        clear_figures();
        m_active = 1;
      end
      FUNC_STOP: m_active = 0;
      default: ;
    endcase
    o.measuring = m_active;
    o.top_speed = m_top_speed;
    o.peak_forward_accel = m_fwd_acc;
    o.peak_braking_decel = m_brake_acc;
    o.launch_time = m_launch_rec;
    o.launch_timing = m_timing;
    o.peak_lateral_accel = m_lat_acc;
    o.speed_at_peak_lateral = m_lat_speed;
    o.radius_at_peak_lateral = m_lat_radius;
    o.tightest_radius = m_min_radius;
    return o;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      if (mismatches < 10)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    vpm_out_t want, pred;
    if (rst_n && in_valid && in_ready) begin
      pred = meter_figures(in_data);
      figures_due.push_back(typed_next ? typed_val : pred);
    end
    if (rst_n && out_valid && out_ready) begin
      if (figures_due.size() == 0) begin
        if (mismatches < 10) $display("mismatch: result with no item pending");
        mismatches++;
      end else begin
        want = figures_due.pop_front();
        check_field("measuring", want.measuring, out_data.measuring);
        check_field("top_speed", want.top_speed, out_data.top_speed);
        check_field("peak_forward_accel", want.peak_forward_accel,
                    out_data.peak_forward_accel);
        check_field("peak_braking_decel", want.peak_braking_decel,
                    out_data.peak_braking_decel);
        check_field("launch_time", want.launch_time, out_data.launch_time);
        check_field("launch_timing", want.launch_timing, out_data.launch_timing);
        check_field("peak_lateral_accel", want.peak_lateral_accel,
                    out_data.peak_lateral_accel);
        check_field("speed_at_peak_lateral", want.speed_at_peak_lateral,
                    out_data.speed_at_peak_lateral);
        check_field("radius_at_peak_lateral", want.radius_at_peak_lateral,
                    out_data.radius_at_peak_lateral);
        check_field("tightest_radius", want.tightest_radius, out_data.tightest_radius);
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (idle_mode == 2) out_ready <= ($urandom_range(99) >= 76);
    else if (idle_mode == 3) out_ready <= ($urandom_range(99) >= 24);
    else out_ready <= 1'b1;
  end

  task automatic send_item(vpm_in_t d, bit typed, vpm_out_t tv);
    int pct;
    pct = (idle_mode == 1) ? 76 : (idle_mode == 3) ? 24 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = d;
    typed_next = typed;
    typed_val = tv;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_plain(func_t f, int fs, int yaw, int dt);
    vpm_in_t d;
    d.func = f;
    d.forward_speed = 20'(fs);
    d.yaw_rate = 20'(yaw);
    d.delta_time = 20'(dt);
    send_item(d, 1'b0, '0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_CORNER: corner_floor = val;
      REG_LAUNCH_TGT: launch_goal = val;
      REG_ARM_LOW:    arm_lo = val;
      REG_ARM_HIGH:   arm_hi = val;
      REG_ABORT:      abort_floor = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (figures_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // one drive: start, a launch-like ramp, cruise, corner and brake, sometimes a stop
  task automatic run_drive(int n);
    int spd, step;
    send_plain(FUNC_START, 0, 0, 0);
    spd = $urandom_range(0, 2 * arm_hi + 400);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        vpm_in_t noise;
        noise = $bits(vpm_in_t)'({$urandom, $urandom, $urandom});
        send_item(noise, 1'b0, '0);
      end else begin
        step = ($urandom_range(3) == 0) ? -int'($urandom_range(20000)) :
               int'($urandom_range(12000));
        spd += step;
        if (spd > 524287) spd = 524287;
        if (spd < -524288) spd = -524288;
        if ($urandom_range(19) == 0) spd = $urandom_range(200);
        send_plain(FUNC_TICK, spd,
                   ($urandom_range(3) == 0) ? $urandom_range(10) : $urandom_range(1048575),
                   ($urandom_range(15) == 0) ? $urandom_range(100) :
                   $urandom_range(101, ($urandom_range(1) == 0) ? 50000 : 1048575));
      end
    end
    if ($urandom_range(1) == 0) send_plain(FUNC_STOP, 0, 0, 0);
  endtask

  initial begin
    vpm_out_t tv;
    vpm_in_t d;
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    typed_next = 1'b0;
    typed_val = '0;
    idle_mode = 0;
    mismatches = 0;
    corner_floor = MinCornerRst;
    launch_goal = LaunchTgtRst;
    arm_lo = ArmLowRst;
    arm_hi = ArmHighRst;
    abort_floor = AbortRst;
    clear_figures();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    dir_rows.push_back('{FUNC_TICK, 5000, 1000, 5000, 1'b1, 1'b0});
    dir_rows.push_back('{FUNC_NONE, -1, 1048575, 1048575, 1'b1, 1'b0});
    dir_rows.push_back('{FUNC_STOP, 0, 0, 0, 1'b1, 1'b0});
    dir_rows.push_back('{FUNC_START, 0, 0, 0, 1'b1, 1'b1});
    dir_rows.push_back('{FUNC_TICK, 1000, 0, 1000, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_TICK, 50000, 5000, 100, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_TICK, 20000, 100000, 100000, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_TICK, 50000, 200000, 1048575, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_TICK, 524287, 1048575, 101, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_TICK, -524288, 6, 1048575, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_TICK, 30000, 7, 200, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_TICK, 20000, 0, 500, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_STOP, 0, 0, 0, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_TICK, 40000, 50000, 5000, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_STOP, 0, 0, 0, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_START, 0, 0, 0, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_TICK, 1000, 500, 20000, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_TICK, 40, 500, 20000, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_TICK, 2000, 500, 20000, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_TICK, 30000, 500, 1048575, 1'b0, 1'b0});
    dir_rows.push_back('{FUNC_NONE, 0, 0, 0, 1'b0, 1'b0});
    foreach (dir_rows[i]) begin
      d.func = dir_rows[i].f;
      d.forward_speed = 20'(dir_rows[i].fs);
      d.yaw_rate = 20'(dir_rows[i].yaw);
      d.delta_time = 20'(dir_rows[i].dt);
      tv = '0;
      tv.measuring = dir_rows[i].meas;
      send_item(d, dir_rows[i].typed, tv);
    end
    drain();

    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_MIN_CORNER, MinCornerRst);
          write_reg(REG_LAUNCH_TGT, LaunchTgtRst);
          write_reg(REG_ARM_LOW, ArmLowRst);
          write_reg(REG_ARM_HIGH, ArmHighRst);
          write_reg(REG_ABORT, AbortRst);
          write_reg(RegUnused, 19'h7FFFF);
        end
        2: begin
          write_reg(REG_MIN_CORNER, '0);
          write_reg(REG_LAUNCH_TGT, '0);
          write_reg(REG_ARM_LOW, '0);
          write_reg(REG_ARM_HIGH, '0);
          write_reg(REG_ABORT, '0);
        end
        4: begin
          write_reg(REG_MIN_CORNER, 19'h7FFFF);
          write_reg(REG_LAUNCH_TGT, 19'h7FFFF);
          write_reg(REG_ARM_LOW, 19'h7FFFF);
          write_reg(REG_ARM_HIGH, 19'h7FFFF);
          write_reg(REG_ABORT, 19'h7FFFF);
        end
        default: begin
          write_reg(REG_MIN_CORNER, CfgW'($urandom_range(0, 40000)));
          write_reg(REG_LAUNCH_TGT, CfgW'($urandom_range(10000, 524287)));
          write_reg(REG_ARM_LOW, CfgW'($urandom_range(0, 2000)));
          write_reg(REG_ARM_HIGH, CfgW'($urandom_range(500, 8000)));
          write_reg(REG_ABORT, CfgW'($urandom_range(0, 1000)));
        end
      endcase
      idle_mode = phase % 4;
      repeat (4) run_drive($urandom_range(10, 26));
      drain();
    end

    if (mismatches == 0 && figures_due.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
